// ===== rtl/grc_pkg.sv =====
// ---------------------------------------------------------------------------
// grc_pkg: shared types and constants of the raycast column renderer
// beat structs, register map, sine table
// ---------------------------------------------------------------------------
package grc_pkg;

   localparam int COLUMNS_DEF  = 120;
   localparam int ROWS_DEF     = 40;
   localparam int MAP_SIDE_DEF = 16;

   localparam logic [15:0] STEP_Q12      = 16'd410;
   localparam logic [15:0] VIEW_SPAN_RST = 16'd10923;
   localparam logic [4:0]  MAX_DEPTH_RST = 5'd16;

   localparam int ADDR_W = 6;
   localparam logic [ADDR_W-1:0] REG_WALL0     = 6'd0;
   localparam logic [ADDR_W-1:0] REG_WALL1     = 6'd8;
   localparam logic [ADDR_W-1:0] REG_WALL2     = 6'd16;
   localparam logic [ADDR_W-1:0] REG_WALL3     = 6'd24;
   localparam logic [ADDR_W-1:0] REG_VIEW_SPAN = 6'd32;
   localparam logic [ADDR_W-1:0] REG_MAX_DEPTH = 6'd40;

   localparam logic [2:0] GLYPH_BLANK  = 3'd0;
   localparam logic [2:0] GLYPH_FULL   = 3'd1;
   localparam logic [2:0] GLYPH_DARK   = 3'd2;
   localparam logic [2:0] GLYPH_MEDIUM = 3'd3;
   localparam logic [2:0] GLYPH_LIGHT  = 3'd4;

   typedef struct packed {
      logic [6:0]  column;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] heading;
   } req_type;

   typedef struct packed {
      logic [5:0]  row;
      logic [2:0]  glyph;
      logic [15:0] wall_distance;
      logic        last_row;
   } rsp_type;

   function automatic logic [14:0] quarter_sine(input logic [6:0] i);
      logic [14:0] v;
      case (i)
         7'd0: v = 15'd0;      7'd1: v = 15'd402;    7'd2: v = 15'd804;
         7'd3: v = 15'd1205;   7'd4: v = 15'd1606;   7'd5: v = 15'd2006;
         7'd6: v = 15'd2404;   7'd7: v = 15'd2801;   7'd8: v = 15'd3196;
         7'd9: v = 15'd3590;   7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
         7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
         7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
         7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
         7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
         7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
         7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
         7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
         7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
         7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
         7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
         7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
         7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
         7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
         7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
         7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
         7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
         7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
         7'd63: v = 15'd16379; 7'd64: v = 15'd16384;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // signed Q1.14 sine of a 256-step angle
   function automatic logic signed [15:0] sine_of(input logic [7:0] s);
      logic [6:0]  idx;
      logic [15:0] mag;
      idx = s[6] ? (7'd64 - {1'b0, s[5:0]}) : {1'b0, s[5:0]};
      mag = {1'b0, quarter_sine(idx)};
      return s[7] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

// ===== rtl/grid_raycast_column_renderer_core.sv =====
// ---------------------------------------------------------------------------
// grid_raycast_column_renderer_core
// casts one ray per column beat over a 16x16 wall map and streams row glyphs
// ---------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | grc_pkg::req_type
//  rsp     | out       | rsp_valid/stall  | grc_pkg::rsp_type
//  csr     | in        | psel/penable     | 64-bit registers at 8*i
//
// a column is busy from its req beat until its last row is loaded (up to
// 160 marches at depth 16), then the idle state takes the next beat: one shared
// signed multiplier handles the angle scale, the reciprocal column divide and
// both march axes, and a restoring divider yields one wall-height bit a cycle
// of a 32-bit quotient. reset is synchronous; state, rsp_valid and csr registers reset.
// a stalled rsp beat holds; req_stall stays high until the last row is loaded.
module grid_raycast_column_renderer_core #(
   parameter int COLUMNS  = grc_pkg::COLUMNS_DEF,
   parameter int ROWS     = grc_pkg::ROWS_DEF,
   parameter int MAP_SIDE = grc_pkg::MAP_SIDE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  grc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output grc_pkg::rsp_type           rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [grc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                csr_pwdata,
   output logic [63:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int  RW        = $clog2(ROWS + 1);
   localparam int  CEW       = RW + 6;
   localparam int  LIM       = MAP_SIDE * 4096;
   localparam logic [31:0] NUMER = 32'(ROWS) << 24;
   localparam logic [31:0] HALF  = 32'(ROWS) * 32'd2048;
   // column*span is below 2^23; reciprocal exact over that range
   localparam int  RS        = 23 + $clog2(COLUMNS);
   localparam logic [63:0] RECIP_W = ((64'd1 << RS) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS);
   localparam logic [23:0] RECIP   = RECIP_W[23:0];

   typedef enum logic [3:0] {
      S_IDLE, S_SCALE, S_DIVC, S_TRIG, S_MX, S_MY, S_DIV, S_CEIL, S_ROWS
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [63:0] wall_ff [4];
   logic [15:0] span_ff;
   logic [4:0]  depth_ff;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) wall_ff[i] <= '0;
         span_ff  <= grc_pkg::VIEW_SPAN_RST;
         depth_ff <= grc_pkg::MAX_DEPTH_RST;
      end else if (wr) begin
         case (csr_paddr)
            grc_pkg::REG_WALL0:     wall_ff[0] <= csr_pwdata;
            grc_pkg::REG_WALL1:     wall_ff[1] <= csr_pwdata;
            grc_pkg::REG_WALL2:     wall_ff[2] <= csr_pwdata;
            grc_pkg::REG_WALL3:     wall_ff[3] <= csr_pwdata;
            grc_pkg::REG_VIEW_SPAN: span_ff    <= csr_pwdata[15:0];
            grc_pkg::REG_MAX_DEPTH: depth_ff   <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         grc_pkg::REG_WALL0:     csr_prdata = wall_ff[0];
         grc_pkg::REG_WALL1:     csr_prdata = wall_ff[1];
         grc_pkg::REG_WALL2:     csr_prdata = wall_ff[2];
         grc_pkg::REG_WALL3:     csr_prdata = wall_ff[3];
         grc_pkg::REG_VIEW_SPAN: csr_prdata = {48'd0, span_ff};
         grc_pkg::REG_MAX_DEPTH: csr_prdata = {59'd0, depth_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // working registers
   grc_pkg::req_type    req_ff;
   logic [31:0]         prod_ff;     // column*span, later remainder
   logic [31:0]         quot_ff;
   logic [5:0]          cnt_ff;
   logic signed [15:0]  sx_ff, sy_ff;
   logic [16:0]         d_ff;
   logic [16:0]         dmax_ff;
   logic signed [18:0]  tx_ff;
   logic [RW-1:0]       y_ff;
   logic signed [CEW-1:0] ceil_ff;
   logic [2:0]          gw_ff;
   logic                rsp_valid_ff;
   grc_pkg::rsp_type    rsp_ff;

   // shared multiplier: 25 x 25 signed
   logic signed [24:0]  mul_a;
   logic signed [24:0]  mul_b;
   logic signed [49:0]  mul_p;
   always_comb begin
      case (state_ff)
         S_MY:    begin mul_a = 25'(sy_ff); mul_b = $signed({8'b0, d_ff}); end
         S_MX:    begin mul_a = 25'(sx_ff); mul_b = $signed({8'b0, d_ff}); end
         S_DIVC:  begin
            mul_a = $signed({1'b0, prod_ff[23:0]});
            mul_b = $signed({1'b0, RECIP});
         end
         default: begin
            mul_a = $signed({9'b0, span_ff});
            mul_b = $signed({18'b0, req_ff.column});
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // floor(p/16384) is an arithmetic shift
   logic signed [20:0] off;
   assign off = 21'(mul_p >>> 14);

   logic signed [18:0] tpos;
   always_comb begin
      if (state_ff == S_MX) tpos = 19'($signed({3'b0, req_ff.pos_x}) + off);
      else                  tpos = 19'($signed({3'b0, req_ff.pos_y}) + off);
   end

   logic        out_x, out_y, wall_hit;
   logic [3:0]  cell_x, cell_y;
   logic [63:0] wrow;
   assign out_x  = tx_ff < 0 || tx_ff >= 19'(LIM);
   assign out_y  = tpos < 0 || tpos >= 19'(LIM);
   assign cell_x = tx_ff[15:12];
   assign cell_y = tpos[15:12];
   assign wrow   = wall_ff[cell_y[3:2]];
   assign wall_hit = wrow[{cell_y[1:0], cell_x}];

   // restoring divider step
   logic [32:0] rem_sh;
   logic        rem_ge;
   logic [31:0] div_den;
   assign div_den = {15'd0, d_ff};
   assign rem_sh  = {prod_ff, quot_ff[31]};
   assign rem_ge  = rem_sh >= {1'b0, div_den};

   // ray angle after column divide
   logic [15:0] ray;
   logic [7:0]  tstep;
   assign ray   = req_ff.heading - {1'b0, span_ff[15:1]} + quot_ff[15:0];
   assign tstep = 8'((17'(ray) + 17'd128) >> 8);

   logic signed [31:0] c12;
   logic signed [CEW-1:0] ceil_v;
   assign c12 = $signed(HALF) - $signed(quot_ff);
   assign ceil_v = (c12 >= 0) ? CEW'(c12 >>> 12) : -CEW'((-c12) >>> 12);

   logic [18:0] d3;
   logic [18:0] dm2;
   assign d3  = 19'(d_ff) * 19'd3;
   assign dm2 = 19'(dmax_ff) << 1;

   logic [2:0] g_row;
   logic signed [CEW-1:0] yv, fl;
   logic [RW+3:0] kk;
   always_comb begin
      yv = $signed(CEW'(y_ff));
      fl = CEW'(ROWS) - ceil_ff;
      kk = (RW+4)'(ROWS) - (RW+4)'(y_ff);
      if (yv <= ceil_ff)        g_row = grc_pkg::GLYPH_BLANK;
      else if (yv <= fl)        g_row = gw_ff;
      else if ((kk << 3) < (RW+4)'(ROWS))      g_row = grc_pkg::GLYPH_DARK;
      else if ((kk << 2) < (RW+4)'(ROWS))      g_row = grc_pkg::GLYPH_MEDIUM;
      else if ((kk << 3) < (RW+4)'(3 * ROWS))  g_row = grc_pkg::GLYPH_LIGHT;
      else                                      g_row = grc_pkg::GLYPH_BLANK;
   end

   logic [4:0] depth_c;
   assign depth_c = (depth_ff == 5'd0) ? 5'd1 : ((depth_ff > 5'd16) ? 5'd16 : depth_ff);

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_SCALE;
         S_SCALE: state_in = S_DIVC;
         S_DIVC:  state_in = S_TRIG;
         S_TRIG:  state_in = (dmax_ff == '0) ? S_DIV : S_MX;
         S_MX:    state_in = S_MY;
         S_MY: begin
            if (out_x || out_y || wall_hit || (d_ff >= dmax_ff)) state_in = S_DIV;
            else state_in = S_MX;
         end
         S_DIV:   if (cnt_ff == 6'd31) state_in = S_CEIL;
         S_CEIL:  state_in = S_ROWS;
         S_ROWS:  if (rsp_free && y_ff == RW'(ROWS - 1)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_free) rsp_valid_ff <= (state_ff == S_ROWS);
         case (state_ff)
            S_IDLE: begin
               if (req_valid) req_ff <= req_data;
               dmax_ff <= 17'(depth_c) << 12;
            end
            S_SCALE: begin
               prod_ff <= 32'(mul_p);
            end
            S_DIVC: begin
               quot_ff <= 32'(mul_p >> RS);
            end
            S_DIV: begin
               prod_ff <= rem_ge ? 32'(rem_sh - {1'b0, div_den}) : rem_sh[31:0];
               quot_ff <= {quot_ff[30:0], rem_ge};
               cnt_ff  <= cnt_ff + 6'd1;
            end
            S_TRIG: begin
               sx_ff <= grc_pkg::sine_of(tstep);
               sy_ff <= grc_pkg::sine_of(tstep + 8'd64);
               d_ff  <= grc_pkg::STEP_Q12[15:0];
               if (dmax_ff == '0) begin
                  prod_ff <= '0; quot_ff <= NUMER; cnt_ff <= '0;
               end
            end
            S_MX: tx_ff <= tpos;
            S_MY: begin
               if (out_x || out_y || wall_hit || d_ff >= dmax_ff) begin
                  if (out_x || out_y) d_ff <= dmax_ff;
                  prod_ff <= '0;
                  quot_ff <= NUMER;
                  cnt_ff  <= '0;
               end else begin
                  d_ff <= d_ff + 17'(grc_pkg::STEP_Q12);
               end
            end
            S_CEIL: begin
               ceil_ff <= ceil_v;
               y_ff    <= '0;
               if (d3 <= 19'(dmax_ff))                     gw_ff <= grc_pkg::GLYPH_FULL;
               else if ((19'(d_ff) << 1) < 19'(dmax_ff))  gw_ff <= grc_pkg::GLYPH_DARK;
               else if (d3 < dm2)                          gw_ff <= grc_pkg::GLYPH_MEDIUM;
               else if (d_ff < dmax_ff)                    gw_ff <= grc_pkg::GLYPH_LIGHT;
               else                                        gw_ff <= grc_pkg::GLYPH_BLANK;
            end
            S_ROWS: begin
               if (rsp_free) begin
                  rsp_ff.row             <= 6'(y_ff);
                  rsp_ff.glyph           <= g_row;
                  rsp_ff.wall_distance   <= d_ff[16] ? 16'hFFFF : d_ff[15:0];
                  rsp_ff.last_row        <= (y_ff == RW'(ROWS - 1));
                  y_ff                   <= y_ff + RW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("req taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");
   a_rows_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_ROWS)
      else $error("rsp beat outside row phase");
   a_dist: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CEIL |-> d_ff <= dmax_ff + 17'(grc_pkg::STEP_Q12))
      else $error("march distance overran");
`endif

endmodule
